// ----- hdl/ps2acc_pkg.sv -----
package ps2acc_pkg;

	// Action codes
	localparam logic [1:0] ACT_RECEIVE = 2'd0;
	localparam logic [1:0] ACT_CLEAR   = 2'd1;
	localparam logic [1:0] ACT_QUERY   = 2'd2;

	// Header bit positions
	localparam int HDR_LEFT   = 0;
	localparam int HDR_RIGHT  = 1;
	localparam int HDR_MIDDLE = 2;
	localparam int HDR_XSIGN  = 4;
	localparam int HDR_YSIGN  = 5;

	localparam logic signed [15:0] SUM_MAX = 16'sh7FFF;
	localparam logic signed [15:0] SUM_MIN = -16'sh8000;
	localparam logic [15:0]        COUNT_MAX = 16'hFFFF;

	// Status of one transaction on the result side
	typedef struct packed {
		logic [2:0]         buttons;
		logic signed [15:0] sum_x;
		logic signed [15:0] sum_y;
		logic [15:0]        count;
		logic               done;
	} status_t;

	// 9-bit two's complement delta, halved toward zero: -128..127
	function automatic logic signed [7:0] halve_delta(input logic [7:0] mag, input logic sign);
		logic signed [8:0] v;
		logic signed [9:0] r;
		v = $signed({sign, mag});
		r = {v[8], v} + {9'd0, sign};
		halve_delta = r[8:1];
	endfunction

	// Saturating add into a 16-bit signed accumulator
	function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
		input logic signed [7:0] b);
		logic signed [16:0] s;
		s = {a[15], a} + {{9{b[7]}}, b};
		if (s > 17'sd32767) begin
			sat_add = SUM_MAX;
		end else if (s < -17'sd32768) begin
			sat_add = SUM_MIN;
		end else begin
			sat_add = s[15:0];
		end
	endfunction

endpackage

// ----- hdl/ps2acc_core.sv -----
module ps2acc_core
	import ps2acc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        commit,
	input  logic [1:0]  action,
	input  logic [7:0]  data_byte,
	input  logic        timeout,
	output status_t     status
);

	localparam logic [1:0] POS_HDR = 2'd0;
	localparam logic [1:0] POS_X   = 2'd1;
	localparam logic [1:0] POS_Y   = 2'd2;

	logic [1:0]         pos_q, pos_d;
	logic [7:0]         header_q, header_d;
	logic [7:0]         x_hold_q, x_hold_d;
	logic [2:0]         buttons_q, buttons_d;
	logic signed [15:0] acc_x_q, acc_x_d;
	logic signed [15:0] acc_y_q, acc_y_d;
	logic [15:0]        count_q, count_d;
	logic               done;

	// Compute next assembly and accumulator state for the current transaction
	always_comb begin
		pos_d     = pos_q;
		header_d  = header_q;
		x_hold_d  = x_hold_q;
		buttons_d = buttons_q;
		acc_x_d   = acc_x_q;
		acc_y_d   = acc_y_q;
		count_d   = count_q;
		done      = 1'b0;
		unique case (action)
			ACT_RECEIVE: begin
				if (timeout) begin
					pos_d = POS_HDR;
				end else begin
					unique case (pos_q)
						POS_X: begin
							x_hold_d = data_byte;
							pos_d    = POS_Y;
						end
						POS_Y: begin
							buttons_d = {header_q[HDR_MIDDLE], header_q[HDR_RIGHT],
								header_q[HDR_LEFT]};
							acc_x_d = sat_add(acc_x_q, halve_delta(x_hold_q, header_q[HDR_XSIGN]));
							acc_y_d = sat_add(acc_y_q, halve_delta(data_byte, header_q[HDR_YSIGN]));
							if (count_q != COUNT_MAX) begin
								count_d = count_q + 16'd1;
							end
							pos_d = POS_HDR;
							done  = 1'b1;
						end
						default: begin
							header_d = data_byte;
							pos_d    = POS_X;
						end
					endcase
				end
			end
			ACT_CLEAR: begin
				acc_x_d = '0;
				acc_y_d = '0;
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	assign status = '{buttons: buttons_d, sum_x: acc_x_d, sum_y: acc_y_d,
		count: count_d, done: done};

	// Commit state when a transaction leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= POS_HDR;
			header_q  <= '0;
			x_hold_q  <= '0;
			buttons_q <= '0;
			acc_x_q   <= '0;
			acc_y_q   <= '0;
			count_q   <= '0;
		end else if (commit) begin
			pos_q     <= pos_d;
			header_q  <= header_d;
			x_hold_q  <= x_hold_d;
			buttons_q <= buttons_d;
			acc_x_q   <= acc_x_d;
			acc_y_q   <= acc_y_d;
			count_q   <= count_d;
		end
	end

`ifndef SYNTHESIS
	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		commit && action == ACT_CLEAR |=> acc_x_q == '0 && acc_y_q == '0 && count_q == '0)
		else $error("clear did not zero accumulators");

	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		commit && count_q == COUNT_MAX && action != ACT_CLEAR |=> count_q == COUNT_MAX)
		else $error("sample count wrapped");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> $stable(pos_q) && $stable(acc_x_q) && $stable(acc_y_q) && $stable(count_q))
		else $error("state changed without a transaction");

	a_done_buttons: assert property (@(posedge clk) disable iff (!arst_n)
		commit && done |=> buttons_q == {$past(header_q[HDR_MIDDLE]),
			$past(header_q[HDR_RIGHT]), $past(header_q[HDR_LEFT])} && pos_q == POS_HDR)
		else $error("completed packet did not latch header buttons");
`endif

endmodule

// ----- hdl/ps2_mouse_packet_accumulator_top.sv -----
// Timing: a result is registered in the input register, then the result register.
// Throughput: one transaction per cycle unless out_stall holds a full result
// register; the state update is a single short cone between the input stage
// and the result register.
// Reset: arst_n asynchronously clears valid flags, packet assembly, buttons,
// accumulators and sample count to zero.
module ps2_mouse_packet_accumulator_top
	import ps2acc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  data_byte,
	input  logic        timeout,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        btn_left,
	output logic        btn_right,
	output logic        btn_middle,
	output logic signed [15:0] sum_x,
	output logic signed [15:0] sum_y,
	output logic [15:0] sample_count,
	output logic        packet_done
);

	logic       valid_s1;
	logic [1:0] action_s1;
	logic [7:0] data_byte_s1;
	logic       timeout_s1;
	logic       out_valid_q;
	status_t    status_q;
	status_t    status;
	logic       out_free;
	logic       advance;

	// Result register can take a new transaction when empty or being drained
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_s1    <= action;
			data_byte_s1 <= data_byte;
			timeout_s1   <= timeout;
		end
	end

	ps2acc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (advance),
		.action    (action_s1),
		.data_byte (data_byte_s1),
		.timeout   (timeout_s1),
		.status    (status)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= status;
		end
	end

	assign out_valid    = out_valid_q;
	assign btn_left     = status_q.buttons[0];
	assign btn_right    = status_q.buttons[1];
	assign btn_middle   = status_q.buttons[2];
	assign sum_x        = status_q.sum_x;
	assign sum_y        = status_q.sum_y;
	assign sample_count = status_q.count;
	assign packet_done  = status_q.done;

endmodule
